>>> sv/cmdf_pkg.sv
// ----------------------------------------------------------------------------
// Control message deframer package
// Result kind codes and header layout constants shared by the deframer.
// ----------------------------------------------------------------------------
package cmdf_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_PAYLOAD   = 2'd0;
    localparam t_kind KIND_EMPTY     = 2'd1;
    localparam t_kind KIND_BAD_HDR   = 2'd2;
    localparam t_kind KIND_TOO_LONG  = 2'd3;

    localparam int HDR_BYTES = 8;

    // Position of each header byte, counted from the start of the message.
    localparam logic [2:0] HDR_VERSION = 3'd0;
    localparam logic [2:0] HDR_TYPE    = 3'd1;
    localparam logic [2:0] HDR_RSVD0   = 3'd2;
    localparam logic [2:0] HDR_RSVD1   = 3'd3;
    localparam logic [2:0] HDR_LEN3    = 3'd4;
    localparam logic [2:0] HDR_LEN2    = 3'd5;
    localparam logic [2:0] HDR_LEN1    = 3'd6;
    localparam logic [2:0] HDR_LEN0    = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VERSION   = 2'd0;
    localparam logic [1:0] CFG_LOW_TYPE  = 2'd1;
    localparam logic [1:0] CFG_HIGH_TYPE = 2'd2;

endpackage

>>> sv/control_message_deframer_core.sv
// ----------------------------------------------------------------------------
// Control message deframer core
// Splits a byte stream into length-prefixed messages and streams payloads out.
// An accepted byte waits in the input register, then its result is registered
// in the result register. One byte per cycle unless a result stalls waiting;
// the two registers let a byte enter while a finished result waits to be taken.
// Reset (synchronous, active low) clears the framing state, the error latch
// and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module control_message_deframer_core
    import cmdf_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,

    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_msg_type,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_of_message,
    output logic [15:0] o_payload_length,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int          MAX_PLEN_INT = MAX_MESSAGE_BYTES - HDR_BYTES;
    localparam int          LW           = $clog2(MAX_PLEN_INT + 1);
    localparam logic [31:0] MAX_PLEN     = 32'(MAX_PLEN_INT);

    // Configuration
    logic [7:0] r_cfg_version;
    logic [7:0] r_cfg_low_type;
    logic [7:0] r_cfg_high_type;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Framing state
    logic [2:0]    r_hdr_cnt;
    logic          r_in_payload;
    logic          r_err;
    logic [7:0]    r_hdr_ver;
    logic [7:0]    r_hdr_type;
    logic          r_rsvd_nz;
    logic [23:0]   r_len_hi;
    logic [15:0]   r_plen16;
    logic [LW-1:0] r_remain;

    logic [2:0]    n_hdr_cnt;
    logic          n_in_payload;
    logic          n_err;
    logic [7:0]    n_hdr_ver;
    logic [7:0]    n_hdr_type;
    logic          n_rsvd_nz;
    logic [23:0]   n_len_hi;
    logic [15:0]   n_plen16;
    logic [LW-1:0] n_remain;

    // Result register
    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [7:0]  r_out_type;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [15:0] r_out_plen;

    logic        res_valid;
    t_kind       res_kind;
    logic [7:0]  res_type;
    logic [7:0]  res_byte;
    logic        res_last;
    logic [15:0] res_plen;

    logic        advance;
    logic [31:0] plen;
    logic        hdr_bad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_version   <= 8'd1;
            r_cfg_low_type  <= 8'd1;
            r_cfg_high_type <= 8'd255;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VERSION:   r_cfg_version   <= i_cfg_data;
                CFG_LOW_TYPE:  r_cfg_low_type  <= i_cfg_data;
                CFG_HIGH_TYPE: r_cfg_high_type <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // The stored byte moves on when it produces no result or the result
    // register is free or being emptied this cycle.
    assign advance = r_in_valid && (!res_valid || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    assign plen    = {r_len_hi, r_in_byte};
    assign hdr_bad = (r_hdr_ver != r_cfg_version) || (r_hdr_type < r_cfg_low_type) ||
                     (r_hdr_type > r_cfg_high_type) || r_rsvd_nz;

    always_comb begin
        n_hdr_cnt    = r_hdr_cnt;
        n_in_payload = r_in_payload;
        n_err        = r_err;
        n_hdr_ver    = r_hdr_ver;
        n_hdr_type   = r_hdr_type;
        n_rsvd_nz    = r_rsvd_nz;
        n_len_hi     = r_len_hi;
        n_plen16     = r_plen16;
        n_remain     = r_remain;
        res_valid    = 1'b0;
        res_kind     = KIND_PAYLOAD;
        res_type     = r_hdr_type;
        res_byte     = 8'd0;
        res_last     = 1'b0;
        res_plen     = 16'd0;

        if (r_in_valid && !r_err) begin
            if (!r_in_payload) begin
                n_hdr_cnt = r_hdr_cnt + 3'd1;
                case (r_hdr_cnt)
                    HDR_VERSION: n_hdr_ver = r_in_byte;
                    HDR_TYPE:    n_hdr_type = r_in_byte;
                    HDR_RSVD0:   n_rsvd_nz = (r_in_byte != 8'd0);
                    HDR_RSVD1:   n_rsvd_nz = r_rsvd_nz || (r_in_byte != 8'd0);
                    HDR_LEN3:    n_len_hi[23:16] = r_in_byte;
                    HDR_LEN2:    n_len_hi[15:8] = r_in_byte;
                    HDR_LEN1:    n_len_hi[7:0] = r_in_byte;
                    HDR_LEN0: begin
                        // Header complete: validate it and decide what follows.
                        if (hdr_bad) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_BAD_HDR;
                            n_err     = 1'b1;
                        end else if (plen > MAX_PLEN) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_TOO_LONG;
                            n_err     = 1'b1;
                        end else if (plen == 32'd0) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_EMPTY;
                            res_last  = 1'b1;
                        end else begin
                            n_in_payload = 1'b1;
                            n_plen16     = plen[15:0];
                            n_remain     = plen[LW-1:0];
                        end
                    end
                    default: ;
                endcase
            end else begin
                res_valid = 1'b1;
                res_kind  = KIND_PAYLOAD;
                res_byte  = r_in_byte;
                res_plen  = r_plen16;
                res_last  = (r_remain == LW'(1));
                n_remain  = r_remain - LW'(1);
                if (res_last) begin
                    n_in_payload = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_hdr_cnt    <= 3'd0;
            r_in_payload <= 1'b0;
            r_err        <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_hdr_cnt    <= n_hdr_cnt;
                r_in_payload <= n_in_payload;
                r_err        <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (advance) begin
            r_hdr_ver  <= n_hdr_ver;
            r_hdr_type <= n_hdr_type;
            r_rsvd_nz  <= n_rsvd_nz;
            r_len_hi   <= n_len_hi;
            r_plen16   <= n_plen16;
            r_remain   <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_kind <= res_kind;
            r_out_type <= res_type;
            r_out_byte <= res_byte;
            r_out_last <= res_last;
            r_out_plen <= res_plen;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_out_kind        = r_out_kind;
    assign o_msg_type        = r_out_type;
    assign o_payload_byte    = r_out_byte;
    assign o_last_of_message = r_out_last;
    assign o_payload_length  = r_out_plen;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Control message deframer regression
// Streams framed messages into the deframer under random back-pressure, with
// register updates between bursts, and checks every result against an
// in-bench prediction. The run ends with one bad header that latches the
// error, followed by bytes that must be swallowed.
// ----------------------------------------------------------------------------
module testbench;
    import cmdf_pkg::*;

    localparam int MAX_MSG       = 65536;
    localparam int MAX_PAYLOAD   = MAX_MSG - HDR_BYTES;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  msg_ty;
        logic [7:0]  data;
        logic        is_last;
        logic [15:0] plen;
    } t_frame_out;

    // Tracks framing state and configuration, and holds the results still due.
    class t_deframe_tracker;
        logic [7:0] hdr [8];
        int         byte_cnt;
        int         total_len;
        bit         latched;
        logic [7:0] version;
        logic [7:0] low_type;
        logic [7:0] high_type;
        t_frame_out due [$];
        int         errors;

        function new();
            restart();
            latched   = 1'b0;
            version   = 8'd1;
            low_type  = 8'd1;
            high_type = 8'd255;
            errors    = 0;
        endfunction

        function void restart();
            foreach (hdr[k]) hdr[k] = '0;
            byte_cnt  = 0;
            total_len = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_VERSION:   version   = val;
                CFG_LOW_TYPE:  low_type  = val;
                CFG_HIGH_TYPE: high_type = val;
                default: ;
            endcase
        endfunction

        function void add(t_kind k, logic [7:0] ty, logic [7:0] d, logic l,
                          logic [15:0] n);
            t_frame_out r;
            r.kind    = k;
            r.msg_ty  = ty;
            r.data    = d;
            r.is_last = l;
            r.plen    = n;
            due.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b);
            logic [31:0]     plen;
            longint unsigned whole;
            logic [7:0]      ty;
            bit              fin;
            if (latched) return;
            if (total_len == 0) begin
                hdr[byte_cnt % 8] = b;
                byte_cnt++;
                if (byte_cnt < HDR_BYTES) return;
                ty = hdr[HDR_TYPE];
                if (hdr[HDR_VERSION] != version || ty < low_type || ty > high_type ||
                    hdr[HDR_RSVD0] != 8'd0 || hdr[HDR_RSVD1] != 8'd0) begin
                    latched = 1'b1;
                    add(KIND_BAD_HDR, ty, 8'd0, 1'b0, 16'd0);
                    return;
                end
                plen  = {hdr[HDR_LEN3], hdr[HDR_LEN2], hdr[HDR_LEN1], hdr[HDR_LEN0]};
                whole = longint'(HDR_BYTES) + longint'(plen);
                if (whole > longint'(MAX_MSG)) begin
                    latched = 1'b1;
                    add(KIND_TOO_LONG, ty, 8'd0, 1'b0, 16'd0);
                    return;
                end
                if (plen == 32'd0) begin
                    add(KIND_EMPTY, ty, 8'd0, 1'b1, 16'd0);
                    restart();
                    return;
                end
                total_len = int'(whole);
                return;
            end
            byte_cnt++;
            fin = (byte_cnt >= total_len);
            add(KIND_PAYLOAD, hdr[HDR_TYPE], b, fin, 16'(total_len - HDR_BYTES));
            if (fin) restart();
        endfunction

        function void match_result(t_frame_out got);
            t_frame_out want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind=%0d type=%02h byte=%02h last=%0d len=%0d",
                         $time, got.kind, got.msg_ty, got.data, got.is_last, got.plen);
                return;
            end
            want = due.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch expected kind=%0d type=%02h byte=%02h last=%0d len=%0d",
                         $time, want.kind, want.msg_ty, want.data, want.is_last, want.plen);
                $display("%0t:          actual   kind=%0d type=%02h byte=%02h last=%0d len=%0d",
                         $time, got.kind, got.msg_ty, got.data, got.is_last, got.plen);
            end
        endfunction

        function int outstanding();
            return due.size();
        endfunction
    endclass

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte       = 8'd0;
    logic        o_valid;
    logic        i_ready           = 1'b0;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_msg_type;
    logic [7:0]  o_payload_byte;
    logic        o_last_of_message;
    logic [15:0] o_payload_length;
    logic        i_cfg_valid       = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index       = CFG_VERSION;
    logic [7:0]  i_cfg_data        = 8'd0;

    t_deframe_tracker sb = new();

    int         sender_gap_pct = 14;
    int         sink_stall_pct = 56;
    int         items_sent     = 0;
    logic [7:0] cfg_ver        = 8'd1;
    logic [7:0] cfg_lo         = 8'd1;
    logic [7:0] cfg_hi         = 8'd255;

    control_message_deframer_core #(
        .MAX_MESSAGE_BYTES(MAX_MSG)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_kind       (o_out_kind),
        .o_msg_type       (o_msg_type),
        .o_payload_byte   (o_payload_byte),
        .o_last_of_message(o_last_of_message),
        .o_payload_length (o_payload_length),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check each accepted result, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.match_result({o_out_kind, o_msg_type, o_payload_byte,
                             o_last_of_message, o_payload_length});
        end
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.take_byte(b);
        items_sent++;
    endtask

    task automatic send_header(input logic [7:0] v, input logic [7:0] ty,
                               input logic [7:0] r0, input logic [7:0] r1,
                               input logic [31:0] len);
        send_byte(v);
        send_byte(ty);
        send_byte(r0);
        send_byte(r1);
        send_byte(len[31:24]);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_message(input logic [7:0] ty, input int len);
        send_header(cfg_ver, ty, 8'd0, 8'd0, 32'(len));
        repeat (len) send_byte(8'($urandom_range(255)));
    endtask

    // Hold the input until every result is out and the pipeline has drained,
    // since header bytes leave nothing behind to wait for.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] v, input logic [7:0] lo,
                              input logic [7:0] hi);
        logic [1:0] regs [3] = '{CFG_VERSION, CFG_LOW_TYPE, CFG_HIGH_TYPE};
        logic [7:0] vals [3];
        vals = '{v, lo, hi};
        settle();
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_register(regs[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
        cfg_ver = v;
        cfg_lo  = lo;
        cfg_hi  = hi;
    endtask

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 0;
        if (r < 85) return $urandom_range(16, 1);
        if (r < 97) return $urandom_range(120, 17);
        return $urandom_range(600, 121);
    endfunction

    task automatic run_phase(input int gap_pct, input int stall_pct, input int n_items);
        int         stop_at;
        logic [7:0] a;
        logic [7:0] b;
        sender_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(9) == 0) begin
                a = pick_reg_value();
                b = pick_reg_value();
                if (a <= b) set_config(pick_reg_value(), a, b);
                else        set_config(pick_reg_value(), b, a);
            end else if ($urandom_range(19) == 0) begin
                settle();
            end
            send_message(8'($urandom_range(cfg_lo, cfg_hi)), pick_length());
        end
    endtask

    // One bad header chosen at random; after it the block must stay silent.
    task automatic inject_fault();
        logic [7:0]  v;
        logic [7:0]  ty;
        logic [7:0]  r0;
        logic [7:0]  r1;
        logic [31:0] len;
        logic [31:0] big;
        set_config(pick_reg_value(), 8'h10, 8'he0);
        v   = cfg_ver;
        ty  = 8'($urandom_range(8'he0, 8'h10));
        r0  = 8'd0;
        r1  = 8'd0;
        len = 32'($urandom_range(20));
        case ($urandom_range(2))
            0:       big = 32'(MAX_PAYLOAD + 1);
            1:       big = 32'hffff_ffff;
            default: big = $urandom() | 32'h0001_0000;
        endcase
        case ($urandom_range(7))
            0: v  = cfg_ver ^ (8'h01 << $urandom_range(7));
            1: ty = 8'($urandom_range(8'h0f, 0));
            2: ty = 8'($urandom_range(8'hff, 8'he1));
            3: r0 = 8'($urandom_range(255, 1));
            4: r1 = 8'($urandom_range(255, 1));
            5: len = big;
            6: begin
                // Empty type range: lowest above highest rejects every type.
                r0 = 8'($urandom_range(255, 1));
                set_config(cfg_ver, r0, r0 - 8'd1);
                r0 = 8'd0;
                ty = 8'($urandom_range(255));
            end
            default: begin
                // Version is checked before the length.
                v   = ~cfg_ver;
                len = big;
            end
        endcase
        send_header(v, ty, r0, r1, len);
        repeat (64) send_byte(8'($urandom_range(255)));
        // Register writes must not release the latch.
        set_config(8'd1, 8'd0, 8'd255);
        send_message(8'($urandom_range(255)), pick_length());
        repeat (32) send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, boundary types and payload byte extremes.
        send_message(8'd1, 0);
        send_header(8'd1, 8'd255, 8'd0, 8'd0, 32'd2);
        send_byte(8'hff);
        send_byte(8'h00);
        set_config(8'd255, 8'd0, 8'd0);
        send_header(8'd255, 8'd0, 8'd0, 8'd0, 32'd1);
        send_byte(8'h80);

        run_phase(14, 56, 420);
        run_phase(56, 14, 420);
        run_phase(0, 0, 420);
        inject_fault();

        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("control_message_deframer_core regression: pass");
        end else begin
            $display("control_message_deframer_core regression: fail");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("%0t: timeout with %0d results outstanding", $time, sb.outstanding());
        $display("control_message_deframer_core regression: fail");
        $finish;
    end

endmodule
